// ----- src/eppp_pkg.sv -----
// eppp_pkg: shared types and constants for the encoder period pid pwm block
// no dependencies
package eppp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W     = 48;
  localparam int unsigned MAG_W      = 47;
  localparam int unsigned SUM_W      = 11;
  localparam int unsigned CNT_W      = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_DIVISOR = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_INTEG_GAIN   = 3'd2,
    CFG_DERIV_GAIN   = 3'd3,
    CFG_TARGET_0     = 3'd4,
    CFG_TARGET_1     = 3'd5,
    CFG_TARGET_2     = 3'd6,
    CFG_TARGET_3     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_TERM,
    ST_DIVI,
    ST_DIV,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  motor_index;
    logic [15:0] capture_time;
    logic [7:0]  overflow_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] duty_motor;
    logic [7:0] duty;
  } out_item_t;

  typedef struct packed {
    logic  load;
    logic  calc;
    logic  mul;
    logic  div_init;
    logic  div_step;
    logic  add_term;
    logic  commit;
    term_e term;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       stopped;
    logic [2:0] gain_nz;
    logic       div_last;
    logic       out_busy;
  } ctrl_sts_t;

endpackage

// ----- src/eppp_ctrl.sv -----
// eppp_ctrl: sequencer for load, per-term multiply/divide and result commit
// depends on eppp_pkg
module eppp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eppp_pkg::ctrl_sts_t sts_i,
  output eppp_pkg::ctrl_cmd_t cmd_o
);
  import eppp_pkg::*;

  state_e state_q, state_d;
  term_e  term_q, term_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= TERM_P;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    cmd_o   = '0;
    cmd_o.term = term_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        term_d     = TERM_P;
        state_d    = ST_TERM;
      end
      ST_TERM: begin
        if (sts_i.stopped) begin
          state_d = ST_OUT;
        end else if (sts_i.gain_nz[term_q]) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_DIVI;
        end else if (term_q == TERM_D) begin
          state_d = ST_OUT;
        end else begin
          term_d = term_e'(term_q + 2'd1);
        end
      end
      ST_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_term = 1'b1;
        if (term_q == TERM_D) begin
          state_d = ST_OUT;
        end else begin
          term_d  = term_e'(term_q + 2'd1);
          state_d = ST_TERM;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/eppp_dp.sv -----
// eppp_dp: config registers, per-motor state, multiplier, serial divider, output register
// depends on eppp_pkg
module eppp_dp #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [eppp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eppp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  eppp_pkg::in_item_t            in_data_i,
  output eppp_pkg::out_item_t           out_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  eppp_pkg::ctrl_cmd_t           cmd_i,
  output eppp_pkg::ctrl_sts_t           sts_o
);
  import eppp_pkg::*;

  localparam int unsigned MW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic [30:0]        divisor_q;
  logic signed [15:0] gain_q [3];
  logic [31:0]        target_q [4];

  logic [15:0]        last_cap_q [MOTOR_COUNT];
  logic [31:0]        last_per_q [MOTOR_COUNT];
  logic signed [31:0] acc_mem_q  [MOTOR_COUNT];

  in_item_t           item_q;
  logic               stop_q;
  logic [31:0]        period_q;
  logic signed [31:0] error_q, dper_q, acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [MAG_W-1:0]   dvd_q;
  logic [31:0]        rem_q;
  logic               neg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [4:0]         mext;
  logic [MW-1:0]      midx;
  logic               in_range;
  logic [31:0]        period_c;
  logic signed [32:0] acc_wide;
  logic signed [31:0] acc_sat, mul_val;
  logic [30:0]        dvs;
  logic [31:0]        trial;
  logic               fits;
  logic [7:0]         mag;
  logic [7:0]         duty_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= 31'd1;
      for (int i = 0; i < 3; i++) gain_q[i] <= '0;
      for (int i = 0; i < 4; i++) target_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_DIVISOR: divisor_q <= cfg_wdata_i[30:0];
        CFG_PROP_GAIN:    gain_q[0] <= cfg_wdata_i[15:0];
        CFG_INTEG_GAIN:   gain_q[1] <= cfg_wdata_i[15:0];
        CFG_DERIV_GAIN:   gain_q[2] <= cfg_wdata_i[15:0];
        CFG_TARGET_0:     target_q[0] <= cfg_wdata_i;
        CFG_TARGET_1:     target_q[1] <= cfg_wdata_i;
        CFG_TARGET_2:     target_q[2] <= cfg_wdata_i;
        CFG_TARGET_3:     target_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign mext     = {3'd0, item_q.motor_index};
  assign midx     = mext[MW-1:0];
  assign in_range = mext < 5'(MOTOR_COUNT);
  assign period_c = 32'(item_q.capture_time) + {8'd0, item_q.overflow_count, 16'd0}
                    - 32'(last_cap_q[midx]);
  assign acc_wide = 33'(acc_mem_q[midx]) + 33'(signed'(period_c - target_q[item_q.motor_index]));
  always_comb begin
    if (acc_wide[32] != acc_wide[31]) acc_sat = acc_wide[32] ? 32'sh80000000 : 32'sh7fffffff;
    else acc_sat = acc_wide[31:0];
  end

  always_comb begin
    case (cmd_i.term)
      TERM_P:  mul_val = error_q;
      TERM_I:  mul_val = acc_q;
      default: mul_val = dper_q;
    endcase
  end

  assign dvs   = (divisor_q == '0) ? 31'd1 : divisor_q;
  assign trial = {rem_q[30:0], dvd_q[MAG_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign mag   = (dvd_q > MAG_W'(255)) ? 8'd255 : dvd_q[7:0];
  assign duty_c = stop_q ? 8'd0 : (sum_q < 0) ? 8'd0 :
                  (sum_q > SUM_W'(255)) ? 8'd255 : sum_q[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.calc) begin
      stop_q   <= (target_q[item_q.motor_index] == '0) || !in_range;
      period_q <= period_c;
      error_q  <= signed'(period_c - target_q[item_q.motor_index]);
      dper_q   <= signed'(period_c - last_per_q[midx]);
      acc_q    <= acc_sat;
      sum_q    <= '0;
    end
    if (cmd_i.mul) prod_q <= PROD_W'(gain_q[cmd_i.term] * mul_val);
    if (cmd_i.div_init) begin
      neg_q <= prod_q[PROD_W-1];
      dvd_q <= prod_q[PROD_W-1] ? MAG_W'(-prod_q) : prod_q[MAG_W-1:0];
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? trial - {1'b0, dvs} : trial;
      dvd_q <= {dvd_q[MAG_W-2:0], fits};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.add_term) sum_q <= neg_q ? sum_q - SUM_W'(mag) : sum_q + SUM_W'(mag);
    if (cmd_i.commit) begin
      out_q.duty_motor <= item_q.motor_index;
      out_q.duty       <= duty_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        last_cap_q[i] <= '0;
        last_per_q[i] <= '0;
        acc_mem_q[i]  <= '0;
      end
    end else if (cmd_i.commit && !stop_q) begin
      last_cap_q[midx] <= item_q.capture_time;
      last_per_q[midx] <= period_q;
      if (gain_q[1] != '0) acc_mem_q[midx] <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.commit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign sts_o.stopped    = stop_q;
  assign sts_o.gain_nz    = {gain_q[2] != '0, gain_q[1] != '0, gain_q[0] != '0};
  assign sts_o.div_last   = cnt_q == CNT_W'(MAG_W - 1);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

// ----- src/encoder_period_pid_pwm.sv -----
// encoder_period_pid_pwm: one item in flight from input beat to result
// an enabled term runs multiply, divider init, the bit-serial divider and add; a disabled one is skipped
// input is taken again once the sequencer is back in idle after the result is written
// asynchronous active-low reset clears config, per-motor state and the output valid flag
// depends on eppp_pkg, eppp_ctrl, eppp_dp
module encoder_period_pid_pwm #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [eppp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eppp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  eppp_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output eppp_pkg::out_item_t             out_data_o
);
  import eppp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  eppp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  eppp_dp #(.MOTOR_COUNT(MOTOR_COUNT)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .in_data_i,
    .out_data_o, .out_valid_o, .out_ready_i, .cmd_i(cmd), .sts_o(sts)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a beat while busy");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.calc, cmd.mul, cmd.div_init, cmd.div_step, cmd.add_term,
              cmd.commit}))
    else $error("overlapping datapath commands");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ({3'd0, out_data_o.duty_motor} >= 5'(MOTOR_COUNT))
    |-> out_data_o.duty == 8'd0)
    else $error("nonzero duty for absent motor");

endmodule

// ----- tb/encoder_period_pid_pwm_tb.sv -----
// encoder_period_pid_pwm_tb: checks captures against a behavioral pid predictor
// drives config writes, directed and random capture beats, random stalls on both sides
// depends on eppp_pkg and encoder_period_pid_pwm
module encoder_period_pid_pwm_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eppp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned N_RANDOM    = 650;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  encoder_period_pid_pwm uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of config and per-motor state
  logic [30:0] divisor_q;
  logic signed [15:0] kp_q, ki_q, kd_q;
  logic [31:0] target_q [4];
  logic [15:0] prev_cap_q [4];
  logic [31:0] prev_period_q [4];
  logic signed [31:0] err_sum_q [4];

  out_item_t duty_queue [$];
  int unsigned error_count = 0;
  int unsigned beats_checked = 0;
  int unsigned cycle_count = 0;
  bit quiet_phase = 1'b0;
  bit long_hold = 1'b0;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    $display("mismatch %0s: got motor %0d duty %0d, want motor %0d duty %0d at %0t",
             what, got.duty_motor, got.duty, want.duty_motor, want.duty, $realtime);
    error_count++;
  endtask

  function automatic logic signed [63:0] pid_term(input logic signed [15:0] gain,
                                                  input logic signed [63:0] value);
    logic signed [63:0] d, q;
    d = (divisor_q == 0) ? 64'sd1 : $signed({33'd0, divisor_q});
    q = (64'(gain) * value) / d;
    if (q > 255) q = 255;
    if (q < -255) q = -255;
    return q;
  endfunction

  function automatic out_item_t predict_duty(input in_item_t it);
    out_item_t r;
    logic [1:0] m;
    logic [31:0] period;
    logic signed [31:0] err;
    logic signed [63:0] acc, total;
    m = it.motor_index;
    r.duty_motor = m;
    r.duty = 8'd0;
    if (target_q[m] == 0) return r;
    period = {16'd0, it.capture_time} + {8'd0, it.overflow_count, 16'd0} - {16'd0, prev_cap_q[m]};
    err = $signed(period - target_q[m]);
    total = 0;
    if (kp_q != 0) total += pid_term(kp_q, 64'(err));
    if (ki_q != 0) begin
      acc = 64'(err_sum_q[m]) + 64'(err);
      if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
      if (acc < -64'sh80000000) acc = -64'sh80000000;
      err_sum_q[m] = acc[31:0];
      total += pid_term(ki_q, acc);
    end
    if (kd_q != 0) total += pid_term(kd_q, 64'($signed(period - prev_period_q[m])));
    if (total > 255) total = 255;
    if (total < 0) total = 0;
    prev_period_q[m] = period;
    prev_cap_q[m] = it.capture_time;
    r.duty = total[7:0];
    return r;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAIN_DIVISOR: divisor_q = val[30:0];
      CFG_PROP_GAIN:    kp_q = val[15:0];
      CFG_INTEG_GAIN:   ki_q = val[15:0];
      CFG_DERIV_GAIN:   kd_q = val[15:0];
      default:          target_q[idx - CFG_TARGET_0] = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // valid stays up after a beat so the next call can follow back to back
  task automatic send_capture(input in_item_t it, input bit fixed, input logic [7:0] fixed_duty);
    out_item_t e;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    e = predict_duty(it);
    if (fixed && e.duty != fixed_duty)
      $display("note: directed row expects duty %0d, predictor %0d", fixed_duty, e.duty);
    if (fixed) e.duty = fixed_duty;
    duty_queue.push_back(e);
  endtask

  function automatic in_item_t mk(input int m, input int c, input int o);
    in_item_t it;
    it.motor_index = 2'(m);
    it.capture_time = 16'(c);
    it.overflow_count = 8'(o);
    return it;
  endfunction

  // receiver: random stall bursts, one long hold to back up the input
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (duty_queue.size() == 0) begin
        report("unexpected beat", out_data_o, '0);
      end else begin
        if (out_data_o !== duty_queue[0]) report("field", out_data_o, duty_queue[0]);
        void'(duty_queue.pop_front());
        beats_checked++;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) out_ready_i <= 1'b0;
      else if (quiet_phase) out_ready_i <= 1'b1;
      else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  typedef struct {
    in_item_t   item;
    bit         fixed;
    logic [7:0] duty;
  } row_t;

  initial begin
    row_t rows [$];
    int hold;
    divisor_q = 31'd1;
    kp_q = 0; ki_q = 0; kd_q = 0;
    for (int i = 0; i < 4; i++) begin
      target_q[i] = 0; prev_cap_q[i] = 0; prev_period_q[i] = 0; err_sum_q[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stopped motors after reset give duty zero
    for (int m = 0; m < 4; m++) send_capture(mk(m, 16'hffff, 8'hff), 1'b1, 8'd0);
    drain();

    write_reg(CFG_GAIN_DIVISOR, 32'd1);
    write_reg(CFG_PROP_GAIN, 32'h0000_7fff);
    write_reg(CFG_INTEG_GAIN, 32'h0000_8000);
    write_reg(CFG_DERIV_GAIN, 32'h0000_0001);
    write_reg(CFG_TARGET_0, 32'd100);
    write_reg(CFG_TARGET_1, 32'hffff_ffff);
    write_reg(CFG_TARGET_2, 32'd1);
    write_reg(CFG_TARGET_3, 32'd0);
    rows.push_back('{mk(0, 0, 0), 1'b0, 8'd0});
    rows.push_back('{mk(0, 16'hffff, 8'hff), 1'b0, 8'd0});   // largest period
    rows.push_back('{mk(0, 0, 0), 1'b0, 8'd0});              // period underflow
    rows.push_back('{mk(1, 5, 0), 1'b0, 8'd0});
    rows.push_back('{mk(1, 16'hffff, 8'hff), 1'b0, 8'd0});
    rows.push_back('{mk(2, 16'h8000, 8'h80), 1'b0, 8'd0});
    rows.push_back('{mk(2, 16'h7fff, 8'h7f), 1'b0, 8'd0});
    rows.push_back('{mk(3, 16'h1234, 8'h12), 1'b1, 8'd0});   // stopped motor
    for (int i = 0; i < 6; i++) rows.push_back('{mk(2, 0, 8'hff), 1'b0, 8'd0}); // sum saturates
    foreach (rows[i]) send_capture(rows[i].item, rows[i].fixed, rows[i].duty);
    drain();

    // zero divisor acts as one
    write_reg(CFG_GAIN_DIVISOR, 32'd0);
    write_reg(CFG_PROP_GAIN, 32'h0000_0000);
    write_reg(CFG_INTEG_GAIN, 32'h0000_7fff);
    write_reg(CFG_TARGET_3, 32'hffff_ffff);
    for (int i = 0; i < 5; i++) send_capture(mk(3, 0, 0), 1'b0, 8'd0);
    drain();
    write_reg(CFG_GAIN_DIVISOR, 32'h7fff_ffff);
    write_reg(CFG_PROP_GAIN, 32'h0000_8000);
    write_reg(CFG_DERIV_GAIN, 32'h0000_8000);
    for (int i = 0; i < 4; i++) send_capture(mk(i, $urandom_range(0, 65535), 8'hff), 1'b0, 8'd0);
    drain();

    // random phases with fresh settings between
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_GAIN_DIVISOR, (ph % 3 == 0) ? $urandom_range(1, 16) : $urandom());
      write_reg(CFG_PROP_GAIN, ($urandom_range(0, 3) == 0) ? 0 : $urandom());
      write_reg(CFG_INTEG_GAIN, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 64));
      write_reg(CFG_DERIV_GAIN, ($urandom_range(0, 3) == 0) ? 0 : $urandom());
      for (int m = 0; m < 4; m++)
        write_reg(cfg_idx_e'(CFG_TARGET_0 + m),
                  ($urandom_range(0, 5) == 0) ? 0 :
                  ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 300000));
      if (ph == 9) quiet_phase = 1'b1;
      if (ph == 4) begin
        fork
          begin
            long_hold = 1'b1;
            hold = 0;
            while (hold < 2000) begin
              @(posedge clk_i);
              hold++;
            end
            long_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < N_RANDOM / 10; i++)
        send_capture(mk($urandom_range(0, 3), $urandom(),
                        ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 4)),
                     1'b0, 8'd0);
      drain();
    end

    $display("covered %0d checked beats over directed extremes and 10 random gain settings",
             beats_checked);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
